// ----- sv/disk_io_fifo_bandwidth_scheduler_core_assert.svh -----
// assertion macros for the disk io scheduler
`ifndef DISK_IO_FIFO_BANDWIDTH_SCHEDULER_CORE_ASSERT_SVH
`define DISK_IO_FIFO_BANDWIDTH_SCHEDULER_CORE_ASSERT_SVH

// same-cycle implication
`define DIBFS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dibfs check failed");

// next-cycle implication
`define DIBFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dibfs check failed");

`endif

// ----- sv/dibfs_pkg.sv -----
// types and constants shared by the disk io scheduler
package dibfs_pkg;

    localparam int unsigned BW_W    = 32;
    localparam int unsigned TAG_W   = 8;
    localparam int unsigned SLOT_W  = 4;
    localparam int unsigned CHF_W   = 5;
    localparam int unsigned RIDX_W  = 4;
    localparam int unsigned KIND_W  = 2;

    localparam logic [CHF_W-1:0] CC_RESET = 5'd4;

    localparam logic MODE_SUBMIT = 1'b0;
    localparam logic MODE_DONE   = 1'b1;

    localparam logic [KIND_W-1:0] KIND_STARTED  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FINISHED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUEUED   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_REJECTED = 2'd3;

    localparam logic [RIDX_W-1:0] REG_FAIR_MODE   = 4'd0;
    localparam logic [RIDX_W-1:0] REG_CHAN_COUNT  = 4'd1;
    localparam logic [RIDX_W-1:0] REG_MAX_RD_BW   = 4'd2;
    localparam logic [RIDX_W-1:0] REG_MAX_WR_BW   = 4'd3;
    localparam logic [RIDX_W-1:0] REG_MAX_RD_CH   = 4'd4;
    localparam logic [RIDX_W-1:0] REG_MAX_WR_CH   = 4'd5;
    localparam logic [RIDX_W-1:0] REG_RD_LATENCY  = 4'd6;
    localparam logic [RIDX_W-1:0] REG_WR_LATENCY  = 4'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUB,
        ST_CPL_RD,
        ST_CPL,
        ST_DIV_GO,
        ST_DIV,
        ST_START
    } t_state;

    typedef struct packed {
        logic              mode;
        logic [TAG_W-1:0]  task_tag;
        logic              is_write;
        logic [BW_W-1:0]   io_length;
        logic [SLOT_W-1:0] done_slot;
    } t_req;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TAG_W-1:0]  tag;
        logic              dir_write;
        logic [BW_W-1:0]   length;
        logic [BW_W-1:0]   granted_bw;
        logic [BW_W-1:0]   base_latency;
        logic [SLOT_W-1:0] slot;
        logic              last;
    } t_res;

    typedef struct packed {
        logic [RIDX_W-1:0] reg_index;
        logic [BW_W-1:0]   wdata;
    } t_cfg_wr;

    typedef struct packed {
        logic             fair_mode;
        logic [CHF_W-1:0] channel_count;
        logic [BW_W-1:0]  max_read_bw;
        logic [BW_W-1:0]  max_write_bw;
        logic [BW_W-1:0]  max_read_bw_per_channel;
        logic [BW_W-1:0]  max_write_bw_per_channel;
        logic [BW_W-1:0]  read_base_latency;
        logic [BW_W-1:0]  write_base_latency;
    } t_cfg_regs;

    typedef struct packed {
        logic            ld_chan;
        logic            ld_rbw;
        logic            ld_wbw;
        logic            clr_share;
        logic [BW_W-1:0] wdata;
    } t_cfg_evt;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic             dir;
        logic [BW_W-1:0]  len;
    } t_qent;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic             dir;
        logic [BW_W-1:0]  bw;
    } t_fent;

endpackage

// ----- sv/dibfs_if.sv -----
// handshake channels of the disk io scheduler: request, result and register write
interface dibfs_req_if import dibfs_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface dibfs_res_if import dibfs_pkg::*; ();
    logic valid;
    logic ready;
    t_res data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface dibfs_cfg_if import dibfs_pkg::*; ();
    logic    valid;
    logic    ready;
    t_cfg_wr data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- sv/dibfs_div.sv -----
// iterative restoring divider, one quotient bit per cycle
module dibfs_div import dibfs_pkg::*; #(
    parameter int unsigned DW = 7
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [BW_W-1:0] i_dividend,
    input  logic [DW-1:0]   i_divisor,
    output logic            o_done,
    output logic [BW_W-1:0] o_quot
);

    localparam int unsigned CNT_W = $clog2(BW_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [BW_W-1:0]  r_acc;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_div;
    logic [BW_W-1:0]  n_acc;
    logic [DW-1:0]    n_rem;
    logic [DW:0]      w_sh;
    logic [DW:0]      w_sub;
    logic             w_ge;

    always_comb begin
        w_sh  = {r_rem, r_acc[BW_W-1]};
        w_ge  = (w_sh >= {1'b0, r_div});
        w_sub = w_sh - {1'b0, r_div};
        n_rem = w_ge ? w_sub[DW-1:0] : w_sh[DW-1:0];
        n_acc = {r_acc[BW_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(BW_W - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_acc;

endmodule

// ----- sv/dibfs_cfg.sv -----
// configuration register file with reload events
module dibfs_cfg import dibfs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    dibfs_cfg_if.sink        i_cfg,
    output t_cfg_regs        o_regs,
    output t_cfg_evt         o_evt
);

    t_cfg_regs r_regs;
    t_cfg_regs n_regs;
    logic      w_wr;

    assign i_cfg.ready = 1'b1;
    assign w_wr        = i_cfg.valid;

    always_comb begin
        n_regs          = r_regs;
        o_evt.ld_chan   = 1'b0;
        o_evt.ld_rbw    = 1'b0;
        o_evt.ld_wbw    = 1'b0;
        o_evt.clr_share = 1'b0;
        o_evt.wdata     = i_cfg.data.wdata;
        if (w_wr) begin
            unique case (i_cfg.data.reg_index)
                REG_FAIR_MODE: begin
                    n_regs.fair_mode = i_cfg.data.wdata[0];
                end
                REG_CHAN_COUNT: begin
                    n_regs.channel_count = i_cfg.data.wdata[CHF_W-1:0];
                    o_evt.ld_chan        = 1'b1;
                    o_evt.clr_share      = 1'b1;
                end
                REG_MAX_RD_BW: begin
                    n_regs.max_read_bw = i_cfg.data.wdata;
                    o_evt.ld_rbw       = 1'b1;
                    o_evt.clr_share    = 1'b1;
                end
                REG_MAX_WR_BW: begin
                    n_regs.max_write_bw = i_cfg.data.wdata;
                    o_evt.ld_wbw        = 1'b1;
                    o_evt.clr_share     = 1'b1;
                end
                REG_MAX_RD_CH: begin
                    n_regs.max_read_bw_per_channel = i_cfg.data.wdata;
                    o_evt.clr_share                = 1'b1;
                end
                REG_MAX_WR_CH: begin
                    n_regs.max_write_bw_per_channel = i_cfg.data.wdata;
                    o_evt.clr_share                 = 1'b1;
                end
                REG_RD_LATENCY: begin
                    n_regs.read_base_latency = i_cfg.data.wdata;
                end
                REG_WR_LATENCY: begin
                    n_regs.write_base_latency = i_cfg.data.wdata;
                end
                default: begin
                    n_regs = r_regs;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs <= '{fair_mode: 1'b0, channel_count: CC_RESET,
                        max_read_bw: '0, max_write_bw: '0,
                        max_read_bw_per_channel: '0, max_write_bw_per_channel: '0,
                        read_base_latency: '0, write_base_latency: '0};
        end else begin
            r_regs <= n_regs;
        end
    end

    assign o_regs = r_regs;

endmodule

// ----- sv/disk_io_fifo_bandwidth_scheduler_core.sv -----
// disk io scheduler: fifo queue of pending tasks with channel and bandwidth grants
//
// i_req carries one word per request: a submit (tag, direction, length) or a
// completion naming an in-flight slot. o_res returns one word per result:
// started, finished, queued or rejected, with last set on the final word of
// a request. A completion of a busy slot gives finished and, when tasks wait,
// a second started word for the queue head. A completion of a free slot
// gives no word. i_cfg writes the registers, one word per register.
// In order, a submit is accepted in idle and decided in the submit state; a
// queued or rejected word is registered from there, a started one from the
// start state. A completion reads the slot table and queue head, gives
// finished from the completion state and the started word of the queue
// head from the start state. A fair share that must be divided anew runs
// the dividers before the start state. One request is worked on at a time.
// The next request is taken while the last word still waits in the output
// register; a stalled receiver holds the work at its emit step only.
// Reset empties the queue, frees all slots, reloads channels and bandwidth
// from the register reset values; the memories need no clearing.
`include "disk_io_fifo_bandwidth_scheduler_core_assert.svh"

module disk_io_fifo_bandwidth_scheduler_core import dibfs_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH  = 16,
    parameter int unsigned MAX_CHANNELS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dibfs_req_if.sink  i_req,
    dibfs_res_if.source o_res,
    dibfs_cfg_if.sink  i_cfg
);

    localparam int unsigned NSLOTS = (MAX_CHANNELS < 16) ? MAX_CHANNELS : 16;
    localparam int unsigned SAW    = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
    localparam int unsigned QAW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QCW    = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned DIVW   = $clog2(MAX_CHANNELS + 1);

    function automatic logic [CHF_W-1:0] f_eff(input logic [CHF_W-1:0] cc);
        logic [CHF_W-1:0] e;
        e = cc;
        if (cc == '0) begin
            e = CHF_W'(1);
        end else if (int'(cc) > MAX_CHANNELS) begin
            e = CHF_W'(MAX_CHANNELS);
        end
        return e;
    endfunction

    t_cfg_regs w_regs;
    t_cfg_evt  w_evt;

    t_state            r_state, n_state;
    t_req              r_req, n_req;
    t_qent             r_st, n_st;
    logic              r_st_pop, n_st_pop;
    logic [CHF_W-1:0]  r_chan_free, n_chan_free;
    logic [BW_W-1:0]   r_rbw_left, n_rbw_left;
    logic [BW_W-1:0]   r_wbw_left, n_wbw_left;
    logic [BW_W-1:0]   r_rshare, n_rshare;
    logic [BW_W-1:0]   r_wshare, n_wshare;
    logic              r_share_ok, n_share_ok;
    logic [QAW-1:0]    r_q_head, n_q_head;
    logic [QAW-1:0]    r_q_tail, n_q_tail;
    logic [QCW-1:0]    r_q_count, n_q_count;
    logic [NSLOTS-1:0] r_busy, n_busy;
    logic              r_out_valid, n_out_valid;
    t_res              r_out, n_out;

    t_qent             r_q_mem [QUEUE_DEPTH];
    t_qent             r_q_rd;
    t_fent             r_f_mem [NSLOTS];
    t_fent             r_f_rd;

    logic              w_q_we, w_q_re, w_f_we, w_f_re;
    t_fent             w_f_wdata;
    logic [SAW-1:0]    w_f_raddr;

    logic              w_out_free;
    logic              w_slot_any;
    logic [SAW-1:0]    w_slot_idx;
    logic [SAW-1:0]    w_ds;
    logic              w_ds_ok;
    logic              w_div_start;
    logic              w_rdiv_done, w_wdiv_done;
    logic [BW_W-1:0]   w_rquot, w_wquot;
    logic [DIVW-1:0]   w_divisor;
    logic [BW_W-1:0]   w_bw, w_left, w_max;
    logic              w_start_fire;
    logic [BW_W:0]     w_sum;
    logic [BW_W-1:0]   w_add_left;

    dibfs_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_regs  (w_regs),
        .o_evt   (w_evt)
    );

    assign w_divisor = DIVW'(f_eff(w_regs.channel_count));

    dibfs_div #(.DW(DIVW)) u_rdiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_regs.max_read_bw),
        .i_divisor  (w_divisor),
        .o_done     (w_rdiv_done),
        .o_quot     (w_rquot)
    );

    dibfs_div #(.DW(DIVW)) u_wdiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_regs.max_write_bw),
        .i_divisor  (w_divisor),
        .o_done     (w_wdiv_done),
        .o_quot     (w_wquot)
    );

    // lowest free in-flight slot
    always_comb begin
        w_slot_any = 1'b0;
        w_slot_idx = '0;
        for (int s = NSLOTS - 1; s >= 0; s--) begin
            if (!r_busy[s]) begin
                w_slot_any = 1'b1;
                w_slot_idx = SAW'(s);
            end
        end
    end

    assign w_ds         = i_req.data.done_slot[SAW-1:0];
    assign w_ds_ok      = ({1'b0, i_req.data.done_slot} < (SLOT_W + 1)'(NSLOTS)) && r_busy[w_ds];
    assign w_out_free   = !r_out_valid || o_res.ready;
    assign w_start_fire = (r_state == ST_START) && w_out_free;
    assign i_req.ready  = (r_state == ST_IDLE);
    assign o_res.valid  = r_out_valid;
    assign o_res.data   = r_out;

    // grant for the task about to start
    always_comb begin
        w_left = r_st.dir ? r_wbw_left : r_rbw_left;
        w_max  = r_st.dir ? w_regs.max_write_bw : w_regs.max_read_bw;
        if (w_regs.fair_mode) begin
            w_bw = r_st.dir ? r_wshare : r_rshare;
        end else begin
            w_bw = (w_left < w_max) ? w_left : w_max;
        end
    end

    // bandwidth returned by a completion
    always_comb begin
        w_sum      = {1'b0, (r_f_rd.dir ? r_wbw_left : r_rbw_left)} + {1'b0, r_f_rd.bw};
        w_add_left = w_sum[BW_W] ? '1 : w_sum[BW_W-1:0];
    end

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_st        = r_st;
        n_st_pop    = r_st_pop;
        n_chan_free = r_chan_free;
        n_rbw_left  = r_rbw_left;
        n_wbw_left  = r_wbw_left;
        n_rshare    = r_rshare;
        n_wshare    = r_wshare;
        n_share_ok  = r_share_ok;
        n_q_head    = r_q_head;
        n_q_tail    = r_q_tail;
        n_q_count   = r_q_count;
        n_busy      = r_busy;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out       = r_out;
        w_q_we      = 1'b0;
        w_q_re      = 1'b0;
        w_f_we      = 1'b0;
        w_f_re      = 1'b0;
        w_f_raddr   = w_ds;
        w_f_wdata   = '{tag: r_st.tag, dir: r_st.dir, bw: w_bw};
        w_div_start = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_req = i_req.data;
                    if (i_req.data.mode == MODE_SUBMIT) begin
                        n_state = ST_SUB;
                    end else if (w_ds_ok) begin
                        w_f_re  = 1'b1;
                        w_q_re  = 1'b1;
                        n_state = ST_CPL_RD;
                    end
                end
            end
            ST_SUB: begin
                if (r_q_count == '0 && r_chan_free != '0 && w_slot_any) begin
                    n_st     = '{tag: r_req.task_tag, dir: r_req.is_write,
                                 len: r_req.io_length};
                    n_st_pop = 1'b0;
                    n_state  = (w_regs.fair_mode && !r_share_ok) ? ST_DIV_GO : ST_START;
                end else if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{kind: KIND_REJECTED, tag: r_req.task_tag,
                                    dir_write: r_req.is_write, length: r_req.io_length,
                                    granted_bw: '0, base_latency: '0, slot: '0,
                                    last: 1'b1};
                    if (r_q_count < QCW'(QUEUE_DEPTH)) begin
                        n_out.kind = KIND_QUEUED;
                        w_q_we     = 1'b1;
                        n_q_tail   = (r_q_tail == QAW'(QUEUE_DEPTH - 1)) ? '0
                                                                        : r_q_tail + QAW'(1);
                        n_q_count  = r_q_count + QCW'(1);
                    end
                    n_state = ST_IDLE;
                end
            end
            ST_CPL_RD: begin
                n_state = ST_CPL;
            end
            ST_CPL: begin
                if (w_out_free) begin
                    n_busy[r_req.done_slot[SAW-1:0]] = 1'b0;
                    if (r_chan_free != '1) begin
                        n_chan_free = r_chan_free + CHF_W'(1);
                    end
                    if (r_f_rd.dir) begin
                        n_wbw_left = w_add_left;
                    end else begin
                        n_rbw_left = w_add_left;
                    end
                    n_out_valid = 1'b1;
                    n_out       = '{kind: KIND_FINISHED, tag: r_f_rd.tag,
                                    dir_write: r_f_rd.dir, length: '0,
                                    granted_bw: '0, base_latency: '0,
                                    slot: r_req.done_slot, last: (r_q_count == '0)};
                    if (r_q_count != '0) begin
                        n_st     = r_q_rd;
                        n_st_pop = 1'b1;
                        n_state  = (w_regs.fair_mode && !r_share_ok) ? ST_DIV_GO
                                                                      : ST_START;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_DIV_GO: begin
                w_div_start = 1'b1;
                n_state     = ST_DIV;
            end
            ST_DIV: begin
                if (w_rdiv_done && w_wdiv_done) begin
                    n_rshare   = (w_rquot < w_regs.max_read_bw_per_channel) ? w_rquot
                                 : w_regs.max_read_bw_per_channel;
                    n_wshare   = (w_wquot < w_regs.max_write_bw_per_channel) ? w_wquot
                                 : w_regs.max_write_bw_per_channel;
                    n_share_ok = 1'b1;
                    n_state    = ST_START;
                end
            end
            ST_START: begin
                if (w_out_free) begin
                    n_chan_free = r_chan_free - CHF_W'(1);
                    if (r_st.dir) begin
                        n_wbw_left = (w_left > w_bw) ? w_left - w_bw : '0;
                    end else begin
                        n_rbw_left = (w_left > w_bw) ? w_left - w_bw : '0;
                    end
                    n_busy[w_slot_idx] = 1'b1;
                    w_f_we             = 1'b1;
                    n_out_valid        = 1'b1;
                    n_out              = '{kind: KIND_STARTED, tag: r_st.tag,
                                           dir_write: r_st.dir, length: r_st.len,
                                           granted_bw: w_bw,
                                           base_latency: r_st.dir ? w_regs.write_base_latency
                                                                  : w_regs.read_base_latency,
                                           slot: SLOT_W'(w_slot_idx), last: 1'b1};
                    if (r_st_pop) begin
                        n_q_head  = (r_q_head == QAW'(QUEUE_DEPTH - 1)) ? '0
                                                                       : r_q_head + QAW'(1);
                        n_q_count = r_q_count - QCW'(1);
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (w_evt.ld_chan) begin
            n_chan_free = f_eff(w_evt.wdata[CHF_W-1:0]);
        end
        if (w_evt.ld_rbw) begin
            n_rbw_left = w_evt.wdata;
        end
        if (w_evt.ld_wbw) begin
            n_wbw_left = w_evt.wdata;
        end
        if (w_evt.clr_share) begin
            n_share_ok = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_st_pop    <= 1'b0;
            r_chan_free <= f_eff(CC_RESET);
            r_rbw_left  <= '0;
            r_wbw_left  <= '0;
            r_share_ok  <= 1'b0;
            r_q_head    <= '0;
            r_q_tail    <= '0;
            r_q_count   <= '0;
            r_busy      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_st_pop    <= n_st_pop;
            r_chan_free <= n_chan_free;
            r_rbw_left  <= n_rbw_left;
            r_wbw_left  <= n_wbw_left;
            r_share_ok  <= n_share_ok;
            r_q_head    <= n_q_head;
            r_q_tail    <= n_q_tail;
            r_q_count   <= n_q_count;
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_st     <= n_st;
        r_rshare <= n_rshare;
        r_wshare <= n_wshare;
        r_out    <= n_out;
    end

    // pending queue memory
    always_ff @(posedge i_clk) begin
        if (w_q_we) begin
            r_q_mem[r_q_tail] <= '{tag: r_req.task_tag, dir: r_req.is_write,
                                   len: r_req.io_length};
        end
        if (w_q_re) begin
            r_q_rd <= r_q_mem[r_q_head];
        end
    end

    // in-flight slot table memory
    always_ff @(posedge i_clk) begin
        if (w_f_we) begin
            r_f_mem[w_slot_idx] <= w_f_wdata;
        end
        if (w_f_re) begin
            r_f_rd <= r_f_mem[w_f_raddr];
        end
    end

    `DIBFS_ASSERT_NOW(a_q_bound, i_clk, i_rst_n, 1'b1, r_q_count <= QCW'(QUEUE_DEPTH))
    `DIBFS_ASSERT_NOW(a_start_chan, i_clk, i_rst_n, r_state == ST_START, r_chan_free != '0)
    `DIBFS_ASSERT_NOW(a_start_slot, i_clk, i_rst_n, r_state == ST_START, w_slot_any)
    `DIBFS_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, w_start_fire, r_busy[$past(w_slot_idx)])

endmodule

// ----- tb/tb.sv -----
// testbench for the disk io scheduler: directed and random requests checked word by word
`timescale 1ns / 100ps

module tb;
    import dibfs_pkg::*;

    localparam int unsigned QDEPTH         = 16;
    localparam int unsigned NSLOT          = 16;
    localparam int unsigned MAXCH          = 16;
    localparam int unsigned ITEMS_PER_PHASE = 125;
    localparam int unsigned SETTLE_CYCLES  = 60;
    localparam int unsigned WATCHDOG_LIMIT = 4000;

    typedef struct {
        logic        fair;
        logic [4:0]  chan_cfg;
        logic [31:0] max_rd, max_wr, cap_rd, cap_wr, lat_rd, lat_wr;
        int unsigned chan_free;
        logic [31:0] rd_left, wr_left, rd_share, wr_share;
        t_qent       pend [QDEPTH];
        int unsigned q_head, q_tail, q_cnt;
        t_fent       flight [NSLOT];
        logic [15:0] busy;
    } t_sched_state;

    logic i_clk;
    logic i_rst_n;

    dibfs_req_if req_ch ();
    dibfs_res_if res_ch ();
    dibfs_cfg_if cfg_ch ();

    disk_io_fifo_bandwidth_scheduler_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    t_sched_state sched_plan;
    t_sched_state sched_live;
    t_req         pending_reqs [$];
    t_cfg_wr      pending_cfgs [$];
    t_res         due_events [$];

    int unsigned mismatches = 0;
    int unsigned idle_cycles = 0;
    bit          req_took = 1'b0;
    bit          cfg_took = 1'b0;
    int unsigned burst_left = 1;
    int unsigned gap_left = 0;
    int unsigned ready_run = 0;
    int unsigned stall_run = 0;

    always #5 i_clk = ~i_clk;

    function automatic int unsigned eff_chan(logic [4:0] c);
        if (c == 5'd0) return 1;
        if (c > MAXCH) return MAXCH;
        return c;
    endfunction

    function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
        logic [32:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    function automatic void sched_reset(output t_sched_state s);
        s.fair = 1'b0;
        s.chan_cfg = CC_RESET;
        s.max_rd = '0; s.max_wr = '0; s.cap_rd = '0; s.cap_wr = '0;
        s.lat_rd = '0; s.lat_wr = '0;
        s.chan_free = eff_chan(CC_RESET);
        s.rd_left = '0; s.wr_left = '0; s.rd_share = '0; s.wr_share = '0;
        for (int k = 0; k < QDEPTH; k++) s.pend[k] = '0;
        for (int k = 0; k < NSLOT; k++) s.flight[k] = '0;
        s.q_head = 0; s.q_tail = 0; s.q_cnt = 0;
        s.busy = '0;
    endfunction

    function automatic void sched_config(inout t_sched_state s, input t_cfg_wr c);
        case (c.reg_index)
            REG_FAIR_MODE: s.fair = c.wdata[0];
            REG_CHAN_COUNT: begin
                s.chan_cfg = c.wdata[4:0];
                s.chan_free = eff_chan(s.chan_cfg);
                s.rd_share = '0; s.wr_share = '0;
            end
            REG_MAX_RD_BW: begin
                s.max_rd = c.wdata; s.rd_left = c.wdata;
                s.rd_share = '0; s.wr_share = '0;
            end
            REG_MAX_WR_BW: begin
                s.max_wr = c.wdata; s.wr_left = c.wdata;
                s.rd_share = '0; s.wr_share = '0;
            end
            REG_MAX_RD_CH: begin
                s.cap_rd = c.wdata; s.rd_share = '0; s.wr_share = '0;
            end
            REG_MAX_WR_CH: begin
                s.cap_wr = c.wdata; s.rd_share = '0; s.wr_share = '0;
            end
            REG_RD_LATENCY: s.lat_rd = c.wdata;
            REG_WR_LATENCY: s.lat_wr = c.wdata;
            default: ;
        endcase
    endfunction

    // grab a channel and the lowest free slot, grant bandwidth
    function automatic bit launch_task(inout t_sched_state s, input logic [7:0] tag,
                                       input logic dir, input logic [31:0] len,
                                       output t_res w);
        int unsigned slot_no;
        int unsigned c;
        logic [31:0] bw, lat, qr, qw;
        w = '0;
        if (s.chan_free == 0) return 1'b0;
        slot_no = NSLOT;
        for (int k = NSLOT - 1; k >= 0; k--) if (!s.busy[k]) slot_no = k;
        if (slot_no == NSLOT) return 1'b0;
        s.chan_free--;
        if (s.rd_share == '0) begin
            c = eff_chan(s.chan_cfg);
            qr = s.max_rd / c;
            qw = s.max_wr / c;
            s.rd_share = (qr < s.cap_rd) ? qr : s.cap_rd;
            s.wr_share = (qw < s.cap_wr) ? qw : s.cap_wr;
        end
        if (!dir) begin
            bw = s.fair ? s.rd_share : ((s.rd_left < s.max_rd) ? s.rd_left : s.max_rd);
            s.rd_left = (s.rd_left > bw) ? s.rd_left - bw : '0;
            lat = s.lat_rd;
        end else begin
            bw = s.fair ? s.wr_share : ((s.wr_left < s.max_wr) ? s.wr_left : s.max_wr);
            s.wr_left = (s.wr_left > bw) ? s.wr_left - bw : '0;
            lat = s.lat_wr;
        end
        s.flight[slot_no].tag = tag;
        s.flight[slot_no].dir = dir;
        s.flight[slot_no].bw = bw;
        s.busy[slot_no] = 1'b1;
        w.kind = KIND_STARTED;
        w.tag = tag;
        w.dir_write = dir;
        w.length = len;
        w.granted_bw = bw;
        w.base_latency = lat;
        w.slot = slot_no[3:0];
        w.last = 1'b1;
        return 1'b1;
    endfunction

    function automatic int schedule_step(inout t_sched_state s, input t_req r,
                                         output t_res w0, output t_res w1);
        t_qent h;
        logic [3:0] ds;
        w0 = '0;
        w1 = '0;
        if (r.mode == MODE_SUBMIT) begin
            if (s.q_cnt == 0) begin
                if (launch_task(s, r.task_tag, r.is_write, r.io_length, w0)) return 1;
            end
            w0 = '0;
            w0.tag = r.task_tag;
            w0.dir_write = r.is_write;
            w0.length = r.io_length;
            w0.last = 1'b1;
            if (s.q_cnt < QDEPTH) begin
                s.pend[s.q_tail].tag = r.task_tag;
                s.pend[s.q_tail].dir = r.is_write;
                s.pend[s.q_tail].len = r.io_length;
                s.q_tail = (s.q_tail + 1 >= QDEPTH) ? 0 : s.q_tail + 1;
                s.q_cnt++;
                w0.kind = KIND_QUEUED;
            end else begin
                w0.kind = KIND_REJECTED;
            end
            return 1;
        end
        ds = r.done_slot;
        if (!s.busy[ds]) return 0;
        s.busy[ds] = 1'b0;
        if (s.chan_free < 31) s.chan_free++;
        if (!s.flight[ds].dir) s.rd_left = sat_add(s.rd_left, s.flight[ds].bw);
        else s.wr_left = sat_add(s.wr_left, s.flight[ds].bw);
        w0.kind = KIND_FINISHED;
        w0.tag = s.flight[ds].tag;
        w0.dir_write = s.flight[ds].dir;
        w0.slot = ds;
        w0.last = 1'b1;
        if (s.q_cnt > 0) begin
            h = s.pend[s.q_head];
            if (launch_task(s, h.tag, h.dir, h.len, w1)) begin
                s.q_head = (s.q_head + 1 >= QDEPTH) ? 0 : s.q_head + 1;
                s.q_cnt--;
                w0.last = 1'b0;
                return 2;
            end
        end
        return 1;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_rate();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(1, 64);
            3: return $urandom_range(100, 100000);
            default: return $urandom;
        endcase
    endfunction

    function automatic void plan_config(logic [RIDX_W-1:0] idx, logic [31:0] val);
        t_cfg_wr w;
        w.reg_index = idx;
        w.wdata = val;
        sched_config(sched_plan, w);
        pending_cfgs.push_back(w);
    endfunction

    function automatic int plan_request(t_req r);
        t_res a, b;
        int n;
        n = schedule_step(sched_plan, r, a, b);
        pending_reqs.push_back(r);
        return n;
    endfunction

    function automatic t_req make_submit(logic [7:0] tag, logic dir, logic [31:0] len);
        t_req r;
        r = '0;
        r.mode = MODE_SUBMIT;
        r.task_tag = tag;
        r.is_write = dir;
        r.io_length = len;
        return r;
    endfunction

    function automatic t_req make_done(logic [3:0] slot_no);
        t_req r;
        r = '0;
        r.mode = MODE_DONE;
        r.done_slot = slot_no;
        return r;
    endfunction

    task automatic settle();
        while (pending_reqs.size() != 0 || req_ch.valid || pending_cfgs.size() != 0 ||
               cfg_ch.valid || due_events.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic random_settings(bit all);
        if (all || $urandom_range(0, 9) < 6) plan_config(REG_FAIR_MODE, $urandom_range(0, 1));
        if (all || $urandom_range(0, 9) < 6) begin
            case ($urandom_range(0, 5))
                0: plan_config(REG_CHAN_COUNT, 0);
                1: plan_config(REG_CHAN_COUNT, 1);
                2: plan_config(REG_CHAN_COUNT, 16);
                3: plan_config(REG_CHAN_COUNT, $urandom_range(17, 31));
                default: plan_config(REG_CHAN_COUNT, $urandom_range(1, 16));
            endcase
        end
        if (all || $urandom_range(0, 9) < 6) plan_config(REG_MAX_RD_BW, pick_rate());
        if (all || $urandom_range(0, 9) < 6) plan_config(REG_MAX_WR_BW, pick_rate());
        if (all || $urandom_range(0, 9) < 6) plan_config(REG_MAX_RD_CH, pick_rate());
        if (all || $urandom_range(0, 9) < 6) plan_config(REG_MAX_WR_CH, pick_rate());
        if (all || $urandom_range(0, 9) < 6) plan_config(REG_RD_LATENCY, rand_word());
        if (all || $urandom_range(0, 9) < 6) plan_config(REG_WR_LATENCY, rand_word());
    endtask

    task automatic random_items();
        t_req r;
        int unsigned roll;
        int unsigned cpl_pct;
        int unsigned n;
        n = 0;
        while (n < ITEMS_PER_PHASE) begin
            roll = $urandom_range(0, 99);
            cpl_pct = (sched_plan.q_cnt >= 12) ? 65 : 40;
            r.task_tag = 8'($urandom_range(0, 255));
            r.is_write = 1'($urandom_range(0, 1));
            r.io_length = rand_word();
            r.done_slot = 4'($urandom_range(0, 15));
            r.mode = MODE_SUBMIT;
            if (roll < 2) begin
                r.mode = MODE_DONE;
            end else if (sched_plan.busy != '0 && roll < cpl_pct) begin
                r.mode = MODE_DONE;
                while (!sched_plan.busy[r.done_slot]) r.done_slot = 4'($urandom_range(0, 15));
            end
            if (plan_request(r) != 0) n++;
        end
    endtask

    // request and register write drivers
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            cfg_ch.valid <= 1'b0;
        end else begin
            if (!(req_ch.valid && !req_took)) begin
                if (gap_left > 0) begin
                    req_ch.valid <= 1'b0;
                    gap_left--;
                end else if (pending_reqs.size() != 0) begin
                    req_ch.data <= pending_reqs[0];
                    pending_reqs.delete(0);
                    req_ch.valid <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 30);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
                    end
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
            if (!(cfg_ch.valid && !cfg_took)) begin
                if (pending_cfgs.size() != 0) begin
                    cfg_ch.data <= pending_cfgs[0];
                    pending_cfgs.delete(0);
                    cfg_ch.valid <= 1'b1;
                end else begin
                    cfg_ch.valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else if (ready_run > 0) begin
            res_ch.ready <= 1'b1;
            ready_run--;
        end else if (stall_run > 0) begin
            res_ch.ready <= 1'b0;
            stall_run--;
        end else begin
            res_ch.ready <= 1'b1;
            ready_run = $urandom_range(1, 40);
            stall_run = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
    end

    // result checker, predictor and watchdog
    always @(posedge i_clk) begin
        t_res w0, w1, want;
        int n;
        req_took <= i_rst_n && req_ch.valid && req_ch.ready;
        cfg_took <= i_rst_n && cfg_ch.valid && cfg_ch.ready;
        if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                if (due_events.size() == 0) begin
                    report_mismatch($sformatf("unexpected word kind %0d tag %0h slot %0d",
                                              res_ch.data.kind, res_ch.data.tag,
                                              res_ch.data.slot));
                end else begin
                    want = due_events[0];
                    due_events.delete(0);
                    compare_field("kind", 32'(res_ch.data.kind), 32'(want.kind));
                    compare_field("tag", 32'(res_ch.data.tag), 32'(want.tag));
                    compare_field("dir_write", 32'(res_ch.data.dir_write),
                                  32'(want.dir_write));
                    compare_field("length", res_ch.data.length, want.length);
                    compare_field("granted_bw", res_ch.data.granted_bw, want.granted_bw);
                    compare_field("base_latency", res_ch.data.base_latency,
                                  want.base_latency);
                    compare_field("slot", 32'(res_ch.data.slot), 32'(want.slot));
                    compare_field("last", 32'(res_ch.data.last), 32'(want.last));
                end
            end
            if (req_ch.valid && req_ch.ready) begin
                n = schedule_step(sched_live, req_ch.data, w0, w1);
                if (n > 0) due_events.push_back(w0);
                if (n > 1) due_events.push_back(w1);
            end
            if (cfg_ch.valid && cfg_ch.ready) sched_config(sched_live, cfg_ch.data);
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        res_ch.ready = 1'b0;
        sched_reset(sched_plan);
        sched_reset(sched_live);
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: fill channels, fill queue, overflow, completions
        plan_config(REG_FAIR_MODE, 0);
        plan_config(REG_CHAN_COUNT, 4);
        plan_config(REG_MAX_RD_BW, 1000);
        plan_config(REG_MAX_WR_BW, 600);
        plan_config(REG_MAX_RD_CH, 300);
        plan_config(REG_MAX_WR_CH, 200);
        plan_config(REG_RD_LATENCY, 11);
        plan_config(REG_WR_LATENCY, 22);
        settle();
        void'(plan_request(make_submit(8'h00, 1'b0, 32'h0000_0000)));
        void'(plan_request(make_submit(8'hFF, 1'b1, 32'hFFFF_FFFF)));
        void'(plan_request(make_submit(8'h55, 1'b0, 32'hAAAA_AAAA)));
        void'(plan_request(make_submit(8'hAA, 1'b1, 32'h5555_5555)));
        for (int k = 0; k < QDEPTH; k++)
            void'(plan_request(make_submit(8'(8'h10 + k), k[0], $urandom)));
        void'(plan_request(make_submit(8'hEE, 1'b1, 32'h1234_5678)));
        void'(plan_request(make_done(4'd0)));
        void'(plan_request(make_done(4'd15)));
        void'(plan_request(make_done(4'd2)));
        void'(plan_request(make_done(4'd1)));
        settle();

        // all registers at their top values
        plan_config(REG_FAIR_MODE, 1);
        plan_config(REG_CHAN_COUNT, 31);
        plan_config(REG_MAX_RD_BW, 32'hFFFF_FFFF);
        plan_config(REG_MAX_WR_BW, 32'hFFFF_FFFF);
        plan_config(REG_MAX_RD_CH, 32'hFFFF_FFFF);
        plan_config(REG_MAX_WR_CH, 32'hFFFF_FFFF);
        plan_config(REG_RD_LATENCY, 32'hFFFF_FFFF);
        plan_config(REG_WR_LATENCY, 32'hFFFF_FFFF);
        settle();
        random_items();
        settle();

        // all registers at their bottom values, but fair mode on
        plan_config(REG_FAIR_MODE, 1);
        plan_config(REG_CHAN_COUNT, 0);
        plan_config(REG_MAX_RD_BW, 0);
        plan_config(REG_MAX_WR_BW, 0);
        plan_config(REG_MAX_RD_CH, 0);
        plan_config(REG_MAX_WR_CH, 0);
        plan_config(REG_RD_LATENCY, 0);
        plan_config(REG_WR_LATENCY, 0);
        settle();
        random_items();
        settle();

        for (int ph = 0; ph < 6; ph++) begin
            random_settings(ph == 0);
            settle();
            random_items();
            settle();
        end

        if (due_events.size() != 0)
            report_mismatch($sformatf("%0d words never arrived", due_events.size()));
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/dibfs_pkg.sv
sv/dibfs_if.sv
sv/dibfs_div.sv
sv/dibfs_cfg.sv
sv/disk_io_fifo_bandwidth_scheduler_core.sv
tb/tb.sv
